[rtl/core/sv39_page_table_walker_defines.svh]
// Assertion macros used by the page table walker RTL.
`ifndef SV39_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define SV39PTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define SV39PTW_ASSERT_NEVER(lbl, prop, msg) \
  `SV39PTW_ASSERT(lbl, !(prop), msg)

`endif

[rtl/core/sv39ptw_pkg.sv]
// Types, constants and codes of the Sv39 page table walker.
`timescale 1ns / 1ps

package sv39ptw_pkg;

  // Local table memory geometry
  localparam int MEM_PAGES      = 8;
  localparam int WORDS_PER_PAGE = 512;
  localparam int MEM_WORDS      = MEM_PAGES * WORDS_PER_PAGE;
  localparam int MEM_ADDR_W     = $clog2(MEM_WORDS);
  localparam int PAGE_W         = (MEM_PAGES > 1) ? $clog2(MEM_PAGES) : 1;

  // Field widths
  localparam int WORD_IDX_W = 12;
  localparam int PTE_W      = 64;
  localparam int VA_W       = 64;
  localparam int PA_W       = 56;
  localparam int PPN_W      = 44;
  localparam int VPN_W      = 9;
  localparam int OFFSET_W   = 12;
  localparam int VA_BITS    = 38;
  localparam int CFG_IDX_W  = 2;

  // Entry bit positions
  localparam int PTE_V       = 0;
  localparam int PTE_U       = 4;
  localparam int PTE_PPN_LSB = 10;

  // Walk levels
  localparam logic [1:0] LEVEL_TOP  = 2'd2;
  localparam logic [1:0] LEVEL_MID  = 2'd1;
  localparam logic [1:0] LEVEL_LEAF = 2'd0;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XLATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_HIGH         = 3'd1,
    STAT_MISSING      = 3'd2,
    STAT_LEAF_INVALID = 3'd3,
    STAT_NOT_USER     = 3'd4,
    STAT_OUTSIDE      = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_PPN    = 2'd0,
    CFG_WINDOW_BASE = 2'd1
  } cfg_idx_e;

  // Input word
  typedef struct packed {
    op_e                   op;
    logic [WORD_IDX_W-1:0] word_index;
    logic [PTE_W-1:0]      word_data;
    logic [VA_W-1:0]       vaddr;
    logic                  require_user;
  } in_item_t;

  // Result word
  typedef struct packed {
    status_e         status;
    logic [PA_W-1:0] phys_addr;
  } out_item_t;

  // Table memory access from the walk controller
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [MEM_ADDR_W-1:0] addr;
    logic [PTE_W-1:0]      wdata;
  } mem_req_t;

endpackage

[rtl/core/sv39ptw_ram.sv]
// Single-port table memory with a registered read.
`timescale 1ns / 1ps

module sv39ptw_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sv39ptw_walk.sv]
// Walk controller: takes words, drives table memory reads and writes, forms results.
`timescale 1ns / 1ps
`include "sv39_page_table_walker_defines.svh"

module sv39ptw_walk
  import sv39ptw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item_i,
  input  logic [PPN_W-1:0] root_ppn_i,
  input  logic [PPN_W-1:0] window_base_ppn_i,
  output mem_req_t         mem_req_o,
  input  logic [PTE_W-1:0] mem_rdata_i,
  output logic             valid_o,
  output out_item_t        res_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } walk_state_e;

  walk_state_e          state_q, state_d;
  logic [1:0]           level_q, level_d;
  logic [PPN_W-1:0]     ppn_q, ppn_d;
  logic [VA_BITS-1:0]   vaddr_q, vaddr_d;
  logic                 user_q, user_d;
  out_item_t            res_q, res_d;
  logic                 valid_q, valid_d;

  logic [PPN_W:0]       win_diff;
  logic                 in_window;
  logic [VPN_W-1:0]     vpn;
  logic                 word_in_range;

  // Offset of the current table page inside the local window
  assign win_diff  = {1'b0, ppn_q} - {1'b0, window_base_ppn_i};
  assign in_window = !win_diff[PPN_W] && (win_diff[PPN_W-1:0] < PPN_W'(MEM_PAGES));

  // Pick the index field of the current level
  always_comb begin
    case (level_q)
      LEVEL_TOP: vpn = {1'b0, vaddr_q[VA_BITS-1:OFFSET_W+2*VPN_W]};
      LEVEL_MID: vpn = vaddr_q[OFFSET_W+2*VPN_W-1:OFFSET_W+VPN_W];
      default:   vpn = vaddr_q[OFFSET_W+VPN_W-1:OFFSET_W];
    endcase
  end

  assign word_in_range = (32'(item_i.word_index) < MEM_WORDS);

  // Walk sequencer
  always_comb begin
    state_d         = state_q;
    level_d         = level_q;
    ppn_d           = ppn_q;
    vaddr_d         = vaddr_q;
    user_d          = user_q;
    res_d           = res_q;
    valid_d         = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = MEM_ADDR_W'(item_i.word_index);
    mem_req_o.wdata = item_i.word_data;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          vaddr_d = item_i.vaddr[VA_BITS-1:0];
          user_d  = item_i.require_user;
          level_d = LEVEL_TOP;
          ppn_d   = root_ppn_i;
          if (item_i.op == OP_WRITE) begin
            mem_req_o.we = word_in_range;
            valid_d      = 1'b1;
            res_d        = '{status: STAT_OK, phys_addr: '0};
          end else if (item_i.vaddr[VA_W-1:VA_BITS] != '0) begin
            valid_d = 1'b1;
            res_d   = '{status: STAT_HIGH, phys_addr: '0};
          end else begin
            state_d = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        if (!in_window) begin
          valid_d = 1'b1;
          res_d   = '{status: STAT_OUTSIDE, phys_addr: '0};
          state_d = S_IDLE;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = MEM_ADDR_W'({win_diff[PAGE_W-1:0], vpn});
          state_d        = S_WAIT;
        end
      end
      S_WAIT: begin
        if (level_q != LEVEL_LEAF) begin
          if (!mem_rdata_i[PTE_V]) begin
            valid_d = 1'b1;
            res_d   = '{status: STAT_MISSING, phys_addr: '0};
            state_d = S_IDLE;
          end else begin
            ppn_d   = mem_rdata_i[PTE_PPN_LSB+PPN_W-1:PTE_PPN_LSB];
            level_d = level_q - 2'd1;
            state_d = S_ISSUE;
          end
        end else begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          if (!mem_rdata_i[PTE_V]) begin
            res_d = '{status: STAT_LEAF_INVALID, phys_addr: '0};
          end else if (user_q && !mem_rdata_i[PTE_U]) begin
            res_d = '{status: STAT_NOT_USER, phys_addr: '0};
          end else begin
            res_d = '{status: STAT_OK,
                      phys_addr: {mem_rdata_i[PTE_PPN_LSB+PPN_W-1:PTE_PPN_LSB],
                                  vaddr_q[OFFSET_W-1:0]}};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Walk context and result word
  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    ppn_q   <= ppn_d;
    vaddr_q <= vaddr_d;
    user_q  <= user_d;
    res_q   <= res_d;
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  `SV39PTW_ASSERT(a_wait_follows_read, (state_q == S_WAIT) |-> $past(mem_req_o.re), "entry check without a read")
  `SV39PTW_ASSERT(a_write_when_idle, mem_req_o.we |-> (state_q == S_IDLE), "table write during a walk")
  `SV39PTW_ASSERT_NEVER(a_read_write_clash, mem_req_o.we && mem_req_o.re, "read and write in one cycle")
  `SV39PTW_ASSERT(a_result_when_idle, valid_q |-> (state_q == S_IDLE), "result shown while walking")

endmodule

[rtl/core/sv39_page_table_walker.sv]
// Sv39 table walker: a table write or too-high address is answered without a walk.
// A walk covers up to three levels, each by sending the address, then a registered entry read.
// The single-port table memory serves one dependent read per level, so words are taken
// one at a time: busy drops in the cycle the result strobe of the previous word shows.
// Reset clears the walk controller, the result strobe and both page number registers;
// table memory content stays undefined until written. The receiver cannot stall results.
`timescale 1ns / 1ps

module sv39_page_table_walker
  import sv39ptw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PPN_W-1:0]     cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_i,
  output logic                 valid_o,
  output out_item_t            res_o
);

  logic [PPN_W-1:0] root_ppn_q;
  logic [PPN_W-1:0] window_base_ppn_q;
  mem_req_t         mem_req;
  logic [PTE_W-1:0] mem_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q        <= '0;
      window_base_ppn_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROOT_PPN:    root_ppn_q        <= cfg_wdata_i;
        CFG_WINDOW_BASE: window_base_ppn_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Walk controller
  sv39ptw_walk u_walk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .item_i            (in_i),
    .root_ppn_i        (root_ppn_q),
    .window_base_ppn_i (window_base_ppn_q),
    .mem_req_o         (mem_req),
    .mem_rdata_i       (mem_rdata),
    .valid_o           (valid_o),
    .res_o             (res_o)
  );

  // Local page table memory
  sv39ptw_ram #(
    .WIDTH  (PTE_W),
    .DEPTH  (MEM_WORDS),
    .ADDR_W (MEM_ADDR_W)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

[verif/sv39ptw_scoreboard.sv]
// Scoreboard for the Sv39 walker: shadows table memory and registers, predicts and checks results.
`timescale 1ns / 1ps

module sv39ptw_scoreboard
  import sv39ptw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PPN_W-1:0]     cfg_wdata_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  in_item_t             word_i,
  input  logic                 res_valid_i,
  input  out_item_t            res_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int REPORT_MAX = 10;

  logic [PTE_W-1:0] table_shadow [MEM_WORDS];
  logic [PPN_W-1:0] root_ppn_q;
  logic [PPN_W-1:0] window_ppn_q;
  out_item_t        awaited_results [$];

  // Map a table page and entry index to a local word address, -1 if outside the window
  function automatic int entry_addr(input logic [PPN_W-1:0] ppn, input logic [VPN_W-1:0] vpn);
    logic [PPN_W-1:0] off;
    if (ppn < window_ppn_q) return -1;
    off = ppn - window_ppn_q;
    if (off >= MEM_PAGES) return -1;
    return int'(off) * WORDS_PER_PAGE + int'(vpn);
  endfunction

  // Apply one accepted word to the shadow state and return the result it must produce
  function automatic out_item_t apply_word(input in_item_t w);
    out_item_t        r;
    logic [PPN_W-1:0] ppn;
    logic [PTE_W-1:0] pte;
    int               addr;
    r.status    = STAT_OK;
    r.phys_addr = '0;
    pte         = '0;
    if (w.op == OP_WRITE) begin
      if (int'(w.word_index) < MEM_WORDS) table_shadow[w.word_index] = w.word_data;
      return r;
    end
    if (w.vaddr[VA_W-1:VA_BITS] != '0) begin
      r.status = STAT_HIGH;
      return r;
    end
    ppn = root_ppn_q;
    // Walk top to leaf; a valid upper entry is always taken as a pointer
    for (int lvl = LEVEL_TOP; lvl >= 0; lvl--) begin
      addr = entry_addr(ppn, w.vaddr[OFFSET_W + VPN_W*lvl +: VPN_W]);
      if (addr < 0) begin
        r.status = STAT_OUTSIDE;
        return r;
      end
      pte = table_shadow[addr];
      if (!pte[PTE_V]) begin
        if (lvl == LEVEL_LEAF) r.status = STAT_LEAF_INVALID;
        else r.status = STAT_MISSING;
        return r;
      end
      ppn = pte[PTE_PPN_LSB +: PPN_W];
    end
    if (w.require_user && !pte[PTE_U]) begin
      r.status = STAT_NOT_USER;
      return r;
    end
    r.phys_addr = {ppn, w.vaddr[OFFSET_W-1:0]};
    return r;
  endfunction

  // Compare results first, then track register writes and accepted words
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      root_ppn_q   = '0;
      window_ppn_q = '0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (res_valid_i) begin
        if (awaited_results.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("[%0t] unexpected result: status %0d pa %h", $time, res_i.status,
                     res_i.phys_addr);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (res_i.status !== want.status || res_i.phys_addr !== want.phys_addr) begin
            if (fail_count_o < REPORT_MAX)
              $display("[%0t] mismatch: expected status %0d pa %h, got status %0d pa %h",
                       $time, want.status, want.phys_addr, res_i.status, res_i.phys_addr);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROOT_PPN) root_ppn_q = cfg_wdata_i;
        else if (cfg_idx_i == CFG_WINDOW_BASE) window_ppn_q = cfg_wdata_i;
      end
      if (start_i && !busy_i) awaited_results.push_back(apply_word(word_i));
      pending_o = awaited_results.size();
    end
  end

endmodule

[verif/testbench.sv]
// Top of the Sv39 walker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import sv39ptw_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int GAP_MAX     = 17;
  localparam int LAST_PHASE  = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [PPN_W-1:0]     cfg_wdata_i = '0;
  logic                 start       = 1'b0;
  logic                 busy;
  in_item_t             word_in     = '0;
  logic                 valid_o;
  out_item_t            res_o;
  int                   fail_count;
  int                   pending;

  logic [PPN_W-1:0] cur_root   = '0;
  logic [PPN_W-1:0] cur_window = '0;
  bit               gaps_on    = 1'b0;
  int               n_writes   = 0;
  int               n_walks    = 0;
  int               n_settings = 1;
  int               cycles     = 0;

  // Table words sent so far, so no walk is started over an unwritten entry
  bit               tbl_known [MEM_WORDS];
  logic [PTE_W-1:0] tbl_words [MEM_WORDS];

  sv39_page_table_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .in_i        (word_in),
    .valid_o     (valid_o),
    .res_o       (res_o)
  );

  sv39ptw_scoreboard walk_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_i      (start),
    .busy_i       (busy),
    .word_i       (word_in),
    .res_valid_i  (valid_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sv39_page_table_walker");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PPN_W-1:0] rand_ppn();
    logic [63:0] t;
    t = rand64();
    return t[PPN_W-1:0];
  endfunction

  // Legal virtual address: bits from VA_BITS upward clear
  function automatic logic [VA_W-1:0] rand_va();
    logic [VA_W-1:0] t;
    t = rand64();
    t[VA_W-1:VA_BITS] = '0;
    return t;
  endfunction

  function automatic logic [VA_W-1:0] make_va(input int vpn2, input int vpn1, input int vpn0);
    logic [VA_W-1:0] t;
    t = rand_va();
    t[OFFSET_W + 2*VPN_W +: VPN_W] = vpn2[VPN_W-1:0];
    t[OFFSET_W + VPN_W +: VPN_W]   = vpn1[VPN_W-1:0];
    t[OFFSET_W +: VPN_W]           = vpn0[VPN_W-1:0];
    return t;
  endfunction

  // Entry with random filler bits around the fields the walk uses
  function automatic logic [PTE_W-1:0] make_pte(input bit v, input bit u,
                                                 input logic [PPN_W-1:0] ppn);
    logic [PTE_W-1:0] p;
    p = rand64();
    p[PTE_V] = v;
    p[PTE_U] = u;
    p[PTE_PPN_LSB +: PPN_W] = ppn;
    return p;
  endfunction

  // Table page number: mostly inside the window, sometimes just past or just below it, or anywhere
  function automatic logic [PPN_W-1:0] pick_table_ppn();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return cur_window + MEM_PAGES;
    if (sel == 1) return cur_window - 1;
    if (sel == 2) return rand_ppn();
    return cur_window + $urandom_range(0, MEM_PAGES - 1);
  endfunction

  function automatic int page_of(input logic [PPN_W-1:0] ppn);
    if (ppn < cur_window) return -1;
    if (ppn - cur_window >= MEM_PAGES) return -1;
    return int'(ppn - cur_window);
  endfunction

  // Check that the walk of va reads only entries that were written
  function automatic bit walk_safe(input logic [VA_W-1:0] va);
    logic [PPN_W-1:0] ppn;
    logic [PTE_W-1:0] pte;
    int               pg;
    int               addr;
    if (va[VA_W-1:VA_BITS] != '0) return 1'b1;
    ppn = cur_root;
    for (int lvl = LEVEL_TOP; lvl >= 0; lvl--) begin
      pg = page_of(ppn);
      if (pg < 0) return 1'b1;
      addr = pg * WORDS_PER_PAGE + int'(va[OFFSET_W + VPN_W*lvl +: VPN_W]);
      if (!tbl_known[addr]) return 1'b0;
      pte = tbl_words[addr];
      if (!pte[PTE_V]) return 1'b1;
      ppn = pte[PTE_PPN_LSB +: PPN_W];
    end
    return 1'b1;
  endfunction

  // Present one word and hold it until the walker takes it
  task automatic send_word(input in_item_t w);
    start   <= 1'b1;
    word_in <= w;
    do @(posedge clk_i); while (busy);
    if (w.op == OP_WRITE) n_writes++;
    else n_walks++;
  endtask

  task automatic send_wr(input logic [WORD_IDX_W-1:0] idx, input logic [PTE_W-1:0] data);
    in_item_t w;
    w.op           = OP_WRITE;
    w.word_index   = idx;
    w.word_data    = data;
    w.vaddr        = rand64();
    w.require_user = 1'($urandom_range(0, 1));
    tbl_known[idx] = 1'b1;
    tbl_words[idx] = data;
    send_word(w);
  endtask

  // Send a walk only when every entry it reads was written
  task automatic send_xl(input logic [VA_W-1:0] va, input bit need_user);
    in_item_t w;
    if (!walk_safe(va)) return;
    w.op           = OP_XLATE;
    w.word_index   = WORD_IDX_W'($urandom_range(0, MEM_WORDS - 1));
    w.word_data    = rand64();
    w.vaddr        = va;
    w.require_user = need_user;
    send_word(w);
  endtask

  task automatic hold_off(input int n);
    if (start) start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, GAP_MAX));
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain();
    if (start) start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PPN_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [PPN_W-1:0] win, input logic [PPN_W-1:0] rt);
    write_reg(CFG_WINDOW_BASE, win);
    write_reg(CFG_ROOT_PPN, rt);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_window = win;
    cur_root   = rt;
    n_settings++;
  endtask

  // Write the three entries on the walk path of va, stopping after an invalid entry or where the path leaves the window
  task automatic map_va(input logic [VA_W-1:0] va, input logic [PTE_W-1:0] top_pte,
                        input logic [PTE_W-1:0] mid_pte, input logic [PTE_W-1:0] leaf_pte);
    int pg;
    pg = page_of(cur_root);
    if (pg < 0) return;
    send_wr(WORD_IDX_W'(pg * WORDS_PER_PAGE + int'(va[OFFSET_W + 2*VPN_W +: VPN_W])),
            top_pte);
    maybe_gap();
    pg = page_of(top_pte[PTE_PPN_LSB +: PPN_W]);
    if (!top_pte[PTE_V] || pg < 0) return;
    send_wr(WORD_IDX_W'(pg * WORDS_PER_PAGE + int'(va[OFFSET_W + VPN_W +: VPN_W])), mid_pte);
    maybe_gap();
    pg = page_of(mid_pte[PTE_PPN_LSB +: PPN_W]);
    if (!mid_pte[PTE_V] || pg < 0) return;
    send_wr(WORD_IDX_W'(pg * WORDS_PER_PAGE + int'(va[OFFSET_W +: VPN_W])), leaf_pte);
    maybe_gap();
  endtask

  // Random traffic: mostly complete mappings followed by walks, the rest loose words
  task automatic random_words(input int target);
    int               first;
    logic [VA_W-1:0]  va;
    first = n_writes + n_walks;
    while (n_writes + n_walks - first < target) begin
      if (page_of(cur_root) >= 0 && $urandom_range(0, 9) < 7) begin
        va = rand_va();
        map_va(va,
               make_pte($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                        pick_table_ppn()),
               make_pte($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                        pick_table_ppn()),
               make_pte($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), rand_ppn()));
        repeat ($urandom_range(1, 2)) begin
          send_xl(va, 1'($urandom_range(0, 1)));
          maybe_gap();
        end
      end else if ($urandom_range(0, 1) == 0) begin
        send_wr(WORD_IDX_W'($urandom_range(0, MEM_WORDS - 1)), rand64());
        maybe_gap();
      end else begin
        send_xl(($urandom_range(0, 3) == 0) ? rand64() : rand_va(), 1'($urandom_range(0, 1)));
        maybe_gap();
      end
    end
  endtask

  initial begin
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] win;
    logic [PPN_W-1:0] rt;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset registers: root is page 0 of a window at 0
    gaps_on = 1'b1;
    send_wr(WORD_IDX_W'(MEM_WORDS - 1), '1);
    send_xl(64'd1 << VA_BITS, 1'b0);
    send_xl('1, 1'b1);
    va = (64'd1 << VA_BITS) - 1;
    map_va(va, make_pte(1'b1, 1'b1, cur_window + 2), make_pte(1'b1, 1'b0, cur_window + 5),
           make_pte(1'b1, 1'b1, '1));
    send_xl(va, 1'b1);
    send_xl(va, 1'b0);
    va = '0;
    map_va(va, make_pte(1'b1, 1'b0, cur_window + 1), make_pte(1'b1, 1'b1, cur_window + 3),
           make_pte(1'b1, 1'b0, rand_ppn()));
    send_xl(va, 1'b1);
    send_xl(va, 1'b0);
    va = make_va(1, 17, 300);
    map_va(va, make_pte(1'b1, 1'b0, cur_window + 4), make_pte(1'b1, 1'b1, cur_window + 6),
           make_pte(1'b0, 1'b1, rand_ppn()));
    send_xl(va, 1'b0);
    va = make_va(2, 40, 7);
    map_va(va, make_pte(1'b1, 1'b1, cur_window + 7), make_pte(1'b0, 1'b1, cur_window + 1),
           '0);
    send_xl(va, 1'b1);
    va = make_va(3, 100, 9);
    map_va(va, make_pte(1'b1, 1'b0, cur_window + MEM_PAGES), '0, '0);
    send_xl(va, 1'b0);
    va = make_va(4, 200, 50);
    map_va(va, make_pte(1'b1, 1'b1, cur_window + 6), make_pte(1'b1, 1'b0, '1), '0);
    send_xl(va, 1'b0);
    drain();

    // Register settings: spare indexes, extremes, root outside, random windows
    write_reg(CFG_SPARE_A, rand_ppn());
    write_reg(CFG_SPARE_B, rand_ppn());
    for (int ph = 1; ph <= LAST_PHASE; ph++) begin
      case (ph)
        1: begin
          win = 44'h000_0001_2340;
          rt  = win + 3;
        end
        2: begin
          win = '1;
          rt  = '1;
        end
        3: begin
          win = '1 - (MEM_PAGES - 1);
          rt  = '1;
        end
        4: begin
          win = rand_ppn();
          rt  = win - 1;
        end
        5: begin
          win = '0;
          rt  = PPN_W'(MEM_PAGES - 1);
        end
        default: begin
          win = rand_ppn();
          rt  = win + $urandom_range(0, MEM_PAGES - 1);
        end
      endcase
      set_regs(win, rt);
      gaps_on = (ph != LAST_PHASE);
      random_words((ph == 4) ? 60 : 120);
      drain();
    end

    // Let any stray result surface before the verdict
    repeat (16) @(posedge clk_i);
    $display("Covered %0d table writes and %0d walks over %0d register settings",
             n_writes, n_walks, n_settings);
    $display("Windows ran from page 0 to the top page, with roots inside and outside them");
    if (fail_count == 0) begin
      $display("PASS sv39_page_table_walker");
    end else begin
      $display("FAIL sv39_page_table_walker");
    end
    $finish;
  end

endmodule
